@@ hw/rtl/sip_pkg.sv @@
// Shared types, codes and helper functions for the string-to-integer parser.
// Used by every module under hw/rtl; depends on nothing.
package sip_pkg;

    localparam int MAX_INT_BYTES = 8;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_X   = 8'h78;   // lowercase 'x' only
    localparam logic [7:0] CH_LA  = 8'h61;
    localparam logic [7:0] CH_LF  = 8'h66;
    localparam logic [7:0] CH_UA  = 8'h41;
    localparam logic [7:0] CH_UF  = 8'h46;

    localparam logic [8:0] USED_MAX  = 9'h1FF;
    localparam logic [7:0] DIGIT_MAX = 8'hFF;

    typedef enum logic [1:0] {
        CFG_WIDTH_CODE = 2'd0,
        CFG_BASE_MODE  = 2'd1,
        CFG_NEGATE     = 2'd2,
        CFG_MAX_DIGITS = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        BM_AUTO = 2'd0,
        BM_DEC  = 2'd1,
        BM_HEX  = 2'd2,
        BM_RSVD = 2'd3
    } t_base_mode;

    typedef enum logic [1:0] {
        ST_PARSING = 2'd0,
        ST_OK      = 2'd1,
        ST_NODIG   = 2'd2,
        ST_OVF     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PH_FIRST  = 3'b001,
        PH_ZERO   = 3'b010,
        PH_DIGITS = 3'b100
    } t_phase;

    typedef struct packed {
        logic [1:0] width_code;
        t_base_mode base_mode;
        logic       negate;
        logic [7:0] max_digits;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic [63:0] value;
        logic [8:0]  chars_used;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit;

    // Largest width code whose byte count fits the given byte budget.
    function automatic logic [1:0] max_code(input int bytes);
        logic [1:0] c;
        if (bytes >= 8)      c = 2'd3;
        else if (bytes >= 4) c = 2'd2;
        else if (bytes >= 2) c = 2'd1;
        else                 c = 2'd0;
        return c;
    endfunction

    function automatic logic [63:0] width_mask(input logic [1:0] code,
                                               input logic [1:0] code_max);
        logic [1:0]  c;
        logic [63:0] m;
        c = (code > code_max) ? code_max : code;
        unique case (c)
            2'd0: m = 64'h0000_0000_0000_00FF;
            2'd1: m = 64'h0000_0000_0000_FFFF;
            2'd2: m = 64'h0000_0000_FFFF_FFFF;
            2'd3: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic t_digit digit_decode(input logic [7:0] ch, input logic hex);
        t_digit     d;
        logic [7:0] dec_v;
        logic [7:0] lo_v;
        logic [7:0] up_v;
        dec_v = ch - CH_0;
        lo_v  = ch - CH_LA + 8'd10;
        up_v  = ch - CH_UA + 8'd10;
        d.ok  = 1'b0;
        d.val = 4'd0;
        if (ch >= CH_0 && ch <= CH_9) begin
            d.ok  = 1'b1;
            d.val = dec_v[3:0];
        end else if (hex && ch >= CH_LA && ch <= CH_LF) begin
            d.ok  = 1'b1;
            d.val = lo_v[3:0];
        end else if (hex && ch >= CH_UA && ch <= CH_UF) begin
            d.ok  = 1'b1;
            d.val = up_v[3:0];
        end
        return d;
    endfunction

endpackage

@@ hw/rtl/sip_cfg.sv @@
// Configuration register file of the string-to-integer parser.
// Depends on sip_pkg.
module sip_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    output sip_pkg::t_cfg        o_cfg
);

    sip_pkg::t_cfg r_cfg;
    sip_pkg::t_cfg n_cfg;
    sip_pkg::t_cfg_idx idx;

    assign o_cfg_ready = 1'b1;
    assign idx = sip_pkg::t_cfg_idx'(i_cfg_index);

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (idx)
                sip_pkg::CFG_WIDTH_CODE: n_cfg.width_code = i_cfg_data[1:0];
                sip_pkg::CFG_BASE_MODE:  n_cfg.base_mode  =
                                             sip_pkg::t_base_mode'(i_cfg_data[1:0]);
                sip_pkg::CFG_NEGATE:     n_cfg.negate     = i_cfg_data[0];
                sip_pkg::CFG_MAX_DIGITS: n_cfg.max_digits = i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_code <= 2'd2;
            r_cfg.base_mode  <= sip_pkg::BM_AUTO;
            r_cfg.negate     <= 1'b0;
            r_cfg.max_digits <= 8'd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/sip_core.sv @@
// Parse state registers and the per-character next-state / result logic.
// Depends on sip_pkg.
module sip_core #(
    parameter int P_MAX_INT_BYTES = sip_pkg::MAX_INT_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_chr,
    input  logic              i_start_req,
    input  sip_pkg::t_cfg     i_cfg,
    output sip_pkg::t_result  o_res
);

    localparam logic [1:0] CODE_MAX = sip_pkg::max_code(P_MAX_INT_BYTES);

    logic [63:0]     r_acc, n_acc;
    logic [7:0]      r_dcnt, n_dcnt;
    logic [8:0]      r_ucnt, n_ucnt;
    sip_pkg::t_phase r_phase, n_phase;
    logic            r_hex, n_hex;
    logic            r_busy, n_busy;
    logic            r_ovf, n_ovf;

    // state as seen by this character (a start request restarts it)
    logic [63:0]     acc_e;
    logic [7:0]      dcnt_e;
    logic [8:0]      ucnt_e;
    sip_pkg::t_phase phase_e;
    logic            hex_e, busy_e, ovf_e;

    sip_pkg::t_digit dig;
    logic [63:0]     mask;
    logic [67:0]     prod;
    logic            ovf_now;
    logic            limit_hit;
    logic            stop;
    logic            is_x;
    logic            prefix_ok;
    logic [63:0]     signed_acc;

    always_comb begin
        acc_e   = i_start_req ? 64'd0 : r_acc;
        dcnt_e  = i_start_req ? 8'd0 : r_dcnt;
        ucnt_e  = i_start_req ? 9'd0 : r_ucnt;
        phase_e = i_start_req ? sip_pkg::PH_FIRST : r_phase;
        hex_e   = i_start_req ? (i_cfg.base_mode == sip_pkg::BM_HEX) : r_hex;
        busy_e  = i_start_req | r_busy;
        ovf_e   = i_start_req ? 1'b0 : r_ovf;

        prefix_ok = (i_cfg.base_mode == sip_pkg::BM_AUTO) ||
                    (i_cfg.base_mode == sip_pkg::BM_HEX);
        mask = sip_pkg::width_mask(i_cfg.width_code, CODE_MAX);
        dig  = sip_pkg::digit_decode(i_chr, hex_e);

        // acc*16+d or acc*10+d, exact, then checked against the width max
        if (hex_e)
            prod = {acc_e, dig.val};
        else
            prod = {1'b0, acc_e, 3'b000} + {3'b000, acc_e, 1'b0} + {64'd0, dig.val};
        ovf_now = prod > {4'd0, mask};

        limit_hit  = (i_cfg.max_digits != 8'd0) && (dcnt_e >= i_cfg.max_digits);
        stop       = (i_chr == sip_pkg::CH_NUL) || !dig.ok || limit_hit;
        is_x       = (phase_e == sip_pkg::PH_ZERO) && (i_chr == sip_pkg::CH_X);
        signed_acc = i_cfg.negate ? (64'd0 - acc_e) : acc_e;

        o_res.status     = sip_pkg::ST_PARSING;
        o_res.value      = 64'd0;
        o_res.chars_used = 9'd0;

        n_acc   = acc_e;
        n_dcnt  = dcnt_e;
        n_ucnt  = ucnt_e;
        n_phase = phase_e;
        n_hex   = hex_e;
        n_busy  = busy_e;
        n_ovf   = ovf_e;

        if (!busy_e) begin
            n_busy = 1'b0;
        end else if (is_x) begin
            n_hex   = 1'b1;
            n_acc   = 64'd0;
            n_dcnt  = 8'd0;
            n_ucnt  = 9'd2;
            n_phase = sip_pkg::PH_DIGITS;
        end else if (stop) begin
            if (ovf_e) begin
                o_res.status = sip_pkg::ST_OVF;
            end else if (dcnt_e == 8'd0) begin
                o_res.status = sip_pkg::ST_NODIG;
            end else begin
                o_res.status = sip_pkg::ST_OK;
                o_res.value  = signed_acc & mask;
            end
            o_res.chars_used = ucnt_e;
            n_busy = 1'b0;
        end else begin
            if (!ovf_e) begin
                if (ovf_now)
                    n_ovf = 1'b1;
                else
                    n_acc = prod[63:0];
            end
            if (dcnt_e != sip_pkg::DIGIT_MAX)
                n_dcnt = dcnt_e + 8'd1;
            if (ucnt_e != sip_pkg::USED_MAX)
                n_ucnt = ucnt_e + 9'd1;
            if ((phase_e == sip_pkg::PH_FIRST) && (i_chr == sip_pkg::CH_0) && prefix_ok)
                n_phase = sip_pkg::PH_ZERO;
            else
                n_phase = sip_pkg::PH_DIGITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= 64'd0;
            r_dcnt  <= 8'd0;
            r_ucnt  <= 9'd0;
            r_phase <= sip_pkg::PH_FIRST;
            r_hex   <= 1'b0;
            r_busy  <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (i_fire) begin
            r_acc   <= n_acc;
            r_dcnt  <= n_dcnt;
            r_ucnt  <= n_ucnt;
            r_phase <= n_phase;
            r_hex   <= n_hex;
            r_busy  <= n_busy;
            r_ovf   <= n_ovf;
        end
    end

endmodule

@@ hw/rtl/sip_out.sv @@
// Result register of the string-to-integer parser; frees the input side
// whenever the held item is taken in the same cycle. Depends on sip_pkg.
module sip_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sip_pkg::t_result  i_res,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sip_pkg::t_result  o_res
);

    logic             r_valid;
    sip_pkg::t_result r_res;
    logic             fire;

    assign o_in_ready = !r_valid || i_out_ready;
    assign fire       = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (fire) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_res       = r_res;

endmodule

@@ hw/rtl/string_to_integer_parser.sv @@
// Top level of the string-to-integer parser: config registers, parse core
// and result register. Depends on sip_pkg, sip_cfg, sip_core, sip_out.
//
//  channel | valid        | ready        | payload
//  --------+--------------+--------------+-------------------------------------
//  input   | i_in_valid   | o_in_ready   | i_chr[7:0], i_start_req
//  result  | o_out_valid  | i_out_ready  | o_status[1:0], o_value[63:0],
//          |              |              | o_chars_used[8:0]
//  config  | i_cfg_valid  | o_cfg_ready  | i_cfg_index[1:0], i_cfg_data[7:0]
//
// One character per cycle unless stalled; every item gives one result, held in the
// output register the cycle after it is taken. The per-cycle limit is the 68-bit
// multiply-by-10/16-and-add plus compare against the width maximum.
// Synchronous reset loads the config defaults and leaves the parser idle.
// The input stalls only while the result register is full and not taken.
module string_to_integer_parser #(
    parameter int P_MAX_INT_BYTES = sip_pkg::MAX_INT_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_chr,
    input  logic        i_start_req,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [63:0] o_value,
    output logic [8:0]  o_chars_used,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    sip_pkg::t_cfg    cfg;
    sip_pkg::t_result core_res;
    sip_pkg::t_result out_res;
    logic             fire;

    assign fire = i_in_valid && o_in_ready;

    sip_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sip_core #(
        .P_MAX_INT_BYTES (P_MAX_INT_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_chr       (i_chr),
        .i_start_req (i_start_req),
        .i_cfg       (cfg),
        .o_res       (core_res)
    );

    sip_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_res       (core_res),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (out_res)
    );

    assign o_status     = out_res.status;
    assign o_value      = out_res.value;
    assign o_chars_used = out_res.chars_used;

endmodule

@@ hw/rtl/sip_checker.sv @@
// Port-level checks for the string-to-integer parser, bound to the top level.
// Depends on sip_pkg and string_to_integer_parser.
module sip_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_chr,
    input logic        i_start_req,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [63:0] o_value,
    input logic [8:0]  o_chars_used,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [1:0]  i_cfg_index,
    input logic [7:0]  i_cfg_data
);

    // held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_value) && $stable(o_status)
            && $stable(o_chars_used))
        else $error("result changed while stalled");

    // every taken item shows up in the result register next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted item gave no result");

    // a full, stalled result register blocks the input side
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while result register blocked");

    // only a clean finish carries a value
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != sip_pkg::ST_OK) |-> o_value == 64'd0)
        else $error("value nonzero without ok status");

    // no character count while still parsing
    a_parse_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == sip_pkg::ST_PARSING) |-> o_chars_used == 9'd0)
        else $error("chars_used nonzero while parsing");

endmodule

bind string_to_integer_parser sip_checker u_sip_checker (.*);
